[hdl/rrss_pkg.sv]
// Package for the round-robin sleep scheduler: request and status codes,
// widths and the controller/datapath command and status structs.
`default_nettype none
package rrss_pkg;
  localparam int MAX_THREADS_DEF = 16;
  localparam int TICK_W = 31;
  localparam int TID_W = 4;

  typedef enum logic [2:0] {
    REQ_ADD = 3'd0, REQ_KILL = 3'd1, REQ_SLEEP = 3'd2, REQ_SWITCH = 3'd3, REQ_TICK = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NO_FREE = 2'd1, ST_NONE_READY = 2'd2, ST_NO_THREAD = 2'd3
  } status_t;

  typedef struct packed {
    logic latch;     // capture request
    logic add;       // link new slot
    logic kill;      // unlink running slot
    logic sleep;     // load running counter
    logic walk_init; // start ring walk
    logic walk_step; // advance ring walk
    logic tick_init; // start tick sweep
    logic tick_step; // advance tick sweep
    logic finish;    // load result
  } cmd_t;

  typedef struct packed {
    req_t    req;
    logic    started;
    logic    free_empty;
    logic    last_live;
    logic    walk_hit;
    logic    walk_done;
    logic    tick_done;
  } sts_t;
endpackage
`default_nettype wire

[hdl/round_robin_sleep_scheduler_unit.sv]
// Top level of the round-robin sleep scheduler: joins rrss_ctrl and
// rrss_datapath. Depends on rrss_pkg.
// One request word in, one result word out, one item in work at a time.
// Add, a refused or ignored request and a kill of the last thread go straight
// to the result; any other kill, and sleep and switch, run a ring walk (one
// slot a cycle, ending at the first awake slot); tick runs a counter sweep
// over all MAX_THREADS slots (one slot a cycle). The result word waits while
// out_tready is low, and the next word is accepted only after it is taken.
`default_nettype none
module round_robin_sleep_scheduler_unit #(
  parameter int MAX_THREADS = rrss_pkg::MAX_THREADS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // req_type[2:0], sleep_ticks[33:3]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // status[1:0], thread_id[5:2]
);
  import rrss_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [1:0] st;
  logic [TID_W-1:0] tid;
  logic nofree, nothr;

  rrss_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts, .err_nofree(nofree), .err_nothread(nothr)
  );

  rrss_datapath #(.MAX_THREADS(MAX_THREADS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req_in(in_tdata[2:0]), .ticks_in(in_tdata[33:3]),
    .status_o(st), .tid_o(tid)
  );

  always_comb begin
    out_tdata = {2'b00, tid, st};
    if (nofree) out_tdata[1:0] = ST_NO_FREE;
    else if (nothr) out_tdata[1:0] = ST_NO_THREAD;
  end
endmodule
`default_nettype wire

[hdl/rrss_datapath.sv]
// Datapath of the scheduler: slot links, sleep counters, free id FIFO.
// Depends on rrss_pkg; driven by rrss_ctrl commands.
`default_nettype none
module rrss_datapath #(
  parameter int MAX_THREADS = rrss_pkg::MAX_THREADS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rrss_pkg::cmd_t          cmd,
  output rrss_pkg::sts_t               sts,
  input  wire logic [2:0]              req_in,
  input  wire logic [rrss_pkg::TICK_W-1:0] ticks_in,
  output logic [1:0]                   status_o,
  output logic [rrss_pkg::TID_W-1:0]   tid_o
);
  import rrss_pkg::*;
  localparam int SW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);

  logic [SW-1:0] next_r [MAX_THREADS];
  logic [SW-1:0] prev_r [MAX_THREADS];
  logic [TICK_W-1:0] cnt_r [MAX_THREADS];
  logic [SW-1:0] fifo_r [MAX_THREADS];
  logic [MAX_THREADS-1:0] live_r;
  logic [SW-1:0] run_r, head_r, walk_r, idx_r, ret_r;
  logic [CW-1:0] fcnt_r, steps_r, live_n_r;
  logic started_r, fifo_init_r;
  logic [TICK_W-1:0] ticks_r;
  req_t req_r;

  logic [SW-1:0] new_id, tail;
  logic [CW:0] tail_sum;

  assign new_id = fifo_init_r ? head_r : fifo_r[head_r];
  assign tail_sum = {1'b0, CW'(head_r)} + {1'b0, fcnt_r};
  assign tail = (tail_sum >= (CW+1)'(MAX_THREADS)) ?
                SW'(tail_sum - (CW+1)'(MAX_THREADS)) : SW'(tail_sum);

  always_comb begin
    sts.req        = req_r;
    sts.started    = started_r;
    sts.free_empty = (fcnt_r == '0);
    sts.last_live  = (live_n_r == CW'(1));
    sts.walk_hit   = (cnt_r[walk_r] == '0);
    sts.walk_done  = (steps_r == '0);
    sts.tick_done  = (idx_r == SW'(MAX_THREADS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      run_r <= '0;
      started_r <= 1'b0;
      head_r <= '0;
      fcnt_r <= CW'(MAX_THREADS);
      live_n_r <= '0;
      fifo_init_r <= 1'b1;
      for (int i = 0; i < MAX_THREADS; i++) cnt_r[i] <= '0;
    end else begin
      if (cmd.latch) begin
        req_r <= req_t'(req_in);
        ticks_r <= ticks_in;
      end
      if (cmd.add) begin
        head_r <= (head_r == SW'(MAX_THREADS - 1)) ? '0 : head_r + SW'(1);
        if (head_r == SW'(MAX_THREADS - 1)) fifo_init_r <= 1'b0;
        fcnt_r <= fcnt_r - CW'(1);
        live_n_r <= live_n_r + CW'(1);
        cnt_r[new_id] <= '0;
        live_r[new_id] <= 1'b1;
        ret_r <= new_id;
        if (!started_r) begin
          next_r[new_id] <= new_id;
          prev_r[new_id] <= new_id;
          run_r <= new_id;
          started_r <= 1'b1;
        end else begin
          prev_r[next_r[run_r]] <= new_id;
          next_r[run_r] <= new_id;
          next_r[new_id] <= next_r[run_r];
          prev_r[new_id] <= run_r;
        end
      end
      if (cmd.kill) begin
        if (fcnt_r != CW'(MAX_THREADS)) begin
          fifo_r[tail] <= run_r;
          fcnt_r <= fcnt_r + CW'(1);
        end
        live_r[run_r] <= 1'b0;
        live_n_r <= live_n_r - CW'(1);
        cnt_r[run_r] <= '0;
        if (live_n_r == CW'(1)) begin
          started_r <= 1'b0;
        end else begin
          next_r[prev_r[run_r]] <= next_r[run_r];
          prev_r[next_r[run_r]] <= prev_r[run_r];
          run_r <= next_r[run_r];
          walk_r <= next_r[run_r];
          steps_r <= live_n_r - CW'(1);
        end
        ret_r <= run_r;
      end
      if (cmd.sleep) cnt_r[run_r] <= ticks_r;
      if (cmd.walk_init) begin
        walk_r <= next_r[run_r];
        steps_r <= live_n_r;
      end
      if (cmd.walk_step) begin
        if (cnt_r[walk_r] == '0) begin
          run_r <= walk_r;
          steps_r <= '0;
        end else begin
          walk_r <= next_r[walk_r];
          steps_r <= steps_r - CW'(1);
        end
      end
      if (cmd.tick_init) idx_r <= '0;
      if (cmd.tick_step) begin
        if (live_r[idx_r] && cnt_r[idx_r] != '0) cnt_r[idx_r] <= cnt_r[idx_r] - TICK_W'(1);
        idx_r <= idx_r + SW'(1);
      end
    end
  end

  // result formed by controller status request
  logic hit_seen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) hit_seen_r <= 1'b0;
    else if (cmd.walk_init || cmd.kill) hit_seen_r <= 1'b0;
    else if (cmd.walk_step && cnt_r[walk_r] == '0 && steps_r != '0) hit_seen_r <= 1'b1;
  end

  logic add_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) add_ok_r <= 1'b0;
    else if (cmd.latch) add_ok_r <= 1'b0;
    else if (cmd.add) add_ok_r <= 1'b1;
  end

  logic [1:0] status_nxt;
  logic [TID_W-1:0] tid_nxt;
  always_comb begin
    status_nxt = ST_OK;
    tid_nxt = TID_W'(run_r);
    case (req_r)
      REQ_ADD: begin
        if (add_ok_r) tid_nxt = TID_W'(ret_r);
      end
      REQ_KILL, REQ_SLEEP, REQ_SWITCH: begin
        if (!started_r || !hit_seen_r) status_nxt = ST_NONE_READY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tid_o <= tid_nxt;
      status_o <= status_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/rrss_ctrl.sv]
// Controller state machine of the scheduler: sequences add, kill, sleep,
// switch and tick work in rrss_datapath. Depends on rrss_pkg.
`default_nettype none
module rrss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output rrss_pkg::cmd_t      cmd,
  input  wire rrss_pkg::sts_t sts,
  output logic                err_nofree,
  output logic                err_nothread
);
  import rrss_pkg::*;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DEC = 7'b0000010, S_WALK = 7'b0000100,
    S_TICK = 7'b0001000, S_FIN = 7'b0010000, S_OUT = 7'b0100000,
    S_INIT = 7'b1000000
  } state_t;
  state_t state_r, state_nxt;
  logic nofree_r, nofree_nxt, nothr_r, nothr_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign err_nofree = nofree_r;
  assign err_nothread = nothr_r;

  always_comb begin
    state_nxt = state_r;
    nofree_nxt = nofree_r;
    nothr_nxt = nothr_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        cmd.latch = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        nofree_nxt = 1'b0;
        nothr_nxt = 1'b0;
        state_nxt = S_FIN;
        case (sts.req)
          REQ_ADD: if (sts.free_empty) nofree_nxt = 1'b1; else cmd.add = 1'b1;
          REQ_KILL: if (!sts.started) nothr_nxt = 1'b1; else begin
            cmd.kill = 1'b1;
            if (!sts.last_live) state_nxt = S_WALK;
          end
          REQ_SLEEP, REQ_SWITCH: if (!sts.started) nothr_nxt = 1'b1; else begin
            cmd.sleep = (sts.req == REQ_SLEEP);
            state_nxt = S_INIT;
          end
          REQ_TICK: begin
            cmd.tick_init = 1'b1;
            state_nxt = S_TICK;
          end
          default: ;
        endcase
      end
      S_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: if (sts.walk_done) state_nxt = S_FIN; else cmd.walk_step = 1'b1;
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.tick_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nofree_r <= 1'b0;
      nothr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nofree_r <= nofree_nxt;
      nothr_r <= nothr_nxt;
    end
  end
endmodule
`default_nettype wire
